@@ src/lkvc_pkg.sv @@
// Shared types and constants of the LRU key-value cache.
// Used by every module under src; depends on nothing.
package lkvc_pkg;

  localparam int Entries  = 16;
  localparam int IdxW     = $clog2(Entries);
  localparam int CntW     = $clog2(Entries + 1);
  localparam int KeyW     = 64;
  localparam int ValW     = 64;
  localparam int LenW     = 4;
  localparam int OpW      = 3;
  localparam int MaxBytes = ValW / 8;

  localparam logic [OpW-1:0] OpInsert   = 3'd0;
  localparam logic [OpW-1:0] OpGet      = 3'd1;
  localparam logic [OpW-1:0] OpUpdate   = 3'd2;
  localparam logic [OpW-1:0] OpRemove   = 3'd3;
  localparam logic [OpW-1:0] OpResetAll = 3'd4;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic [LenW-1:0] value_bytes;
  } in_t;

  typedef struct packed {
    logic            hit;
    logic            status;
    logic            evicted;
    logic [ValW-1:0] value_out;
    logic [LenW-1:0] value_bytes_out;
    logic [CntW-1:0] used_count;
    logic [CntW-1:0] free_count;
  } out_t;

  // Recency table commands
  typedef enum logic [2:0] {
    RankNone  = 3'd0,
    RankTouch = 3'd1,
    RankPush  = 3'd2,
    RankDrop  = 3'd3,
    RankClear = 3'd4
  } rank_op_e;

  typedef struct packed {
    rank_op_e        op;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] rank;
  } rank_cmd_t;

  // Outcome of one pass over the store
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic [IdxW-1:0] hit_rank;
    logic [ValW-1:0] hit_value;
    logic [LenW-1:0] hit_len;
    logic            free_found;
    logic [IdxW-1:0] free_idx;
    logic [IdxW-1:0] lru_idx;
    logic [IdxW-1:0] lru_rank;
  } scan_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StWait = 5'b00100,
    StExec = 5'b01000,
    StResp = 5'b10000
  } state_e;

endpackage

@@ src/lru_key_value_cache.sv @@
// LRU key-value cache, 16 entries, fully associative, one result per item.
// Sequence: a read of every entry in StScan, a compare drain in StWait, the
// update in StExec, then the result in StResp; no new item is taken until the
// result has been taken. The single key comparator visits one entry a cycle.
// Reset: all entries free, ranks and counts zero; key and value memories not cleared.
module lru_key_value_cache (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lkvc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lkvc_pkg::out_t  out_data_o
);

  lkvc_pkg::state_e            state_q, state_d;
  lkvc_pkg::in_t               item_q;
  lkvc_pkg::out_t              res_q, res_d;
  logic [lkvc_pkg::IdxW-1:0]   scan_idx_q, scan_idx_d;
  logic                        cmp_en_q;
  logic [lkvc_pkg::IdxW-1:0]   cmp_idx_q;
  logic                        accept;

  logic [lkvc_pkg::KeyW-1:0]   rd_key;
  logic [lkvc_pkg::ValW-1:0]   rd_value;
  logic [lkvc_pkg::LenW-1:0]   rd_len;
  logic                        rd_valid;
  logic [lkvc_pkg::IdxW-1:0]   rd_rank;
  logic [lkvc_pkg::CntW-1:0]   total;
  lkvc_pkg::scan_t             scan;
  lkvc_pkg::rank_cmd_t         rank_cmd;

  logic                        wr_en;
  logic                        wr_key_en;
  logic [lkvc_pkg::IdxW-1:0]   wr_addr;
  logic [lkvc_pkg::ValW-1:0]   wr_value;
  logic [lkvc_pkg::LenW-1:0]   len_sat;
  logic [lkvc_pkg::ValW-1:0]   byte_mask;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == lkvc_pkg::StIdle);
  assign out_valid_o = (state_q == lkvc_pkg::StResp);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    unique case (state_q)
      lkvc_pkg::StIdle: begin
        scan_idx_d = '0;
        if (in_valid_i) begin
          state_d = lkvc_pkg::StScan;
        end
      end
      lkvc_pkg::StScan: begin
        scan_idx_d = scan_idx_q + 1'b1;
        if (scan_idx_q == lkvc_pkg::IdxW'(lkvc_pkg::Entries - 1)) begin
          state_d = lkvc_pkg::StWait;
        end
      end
      lkvc_pkg::StWait: state_d = lkvc_pkg::StExec;
      lkvc_pkg::StExec: state_d = lkvc_pkg::StResp;
      lkvc_pkg::StResp: begin
        if (out_ready_i) begin
          state_d = lkvc_pkg::StIdle;
        end
      end
      default: state_d = lkvc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lkvc_pkg::StIdle;
      scan_idx_q <= '0;
      cmp_en_q   <= 1'b0;
      cmp_idx_q  <= '0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      cmp_en_q   <= (state_q == lkvc_pkg::StScan);
      cmp_idx_q  <= scan_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (state_q == lkvc_pkg::StExec) begin
      res_q <= res_d;
    end
  end

  // Value length saturates at a full word; keep only the low bytes
  always_comb begin
    len_sat = (item_q.value_bytes > lkvc_pkg::LenW'(lkvc_pkg::MaxBytes)) ?
              lkvc_pkg::LenW'(lkvc_pkg::MaxBytes) : item_q.value_bytes;
    for (int b = 0; b < lkvc_pkg::MaxBytes; b++) begin
      byte_mask[b*8 +: 8] = (lkvc_pkg::LenW'(b) < len_sat) ? 8'hFF : 8'h00;
    end
  end

  assign wr_value = item_q.value & byte_mask;

  // Update step: decide writes, recency change and result fields
  always_comb begin
    res_d     = '0;
    wr_en     = 1'b0;
    wr_key_en = 1'b0;
    wr_addr   = scan.hit_idx;
    rank_cmd  = '{op: lkvc_pkg::RankNone, idx: scan.hit_idx, rank: scan.hit_rank};
    if (state_q == lkvc_pkg::StExec) begin
      res_d.hit = scan.hit && (item_q.op <= lkvc_pkg::OpRemove);
      if ((item_q.op == lkvc_pkg::OpInsert || item_q.op == lkvc_pkg::OpUpdate) &&
          item_q.value_bytes == '0) begin
        res_d.status = 1'b1;
      end else if (item_q.op == lkvc_pkg::OpInsert) begin
        wr_en = 1'b1;
        if (scan.hit) begin
          rank_cmd.op = lkvc_pkg::RankTouch;
        end else if (scan.free_found) begin
          wr_key_en    = 1'b1;
          wr_addr      = scan.free_idx;
          rank_cmd.op  = lkvc_pkg::RankPush;
          rank_cmd.idx = scan.free_idx;
        end else begin
          // full: reuse the oldest entry
          wr_key_en     = 1'b1;
          wr_addr       = scan.lru_idx;
          rank_cmd.op   = lkvc_pkg::RankTouch;
          rank_cmd.idx  = scan.lru_idx;
          rank_cmd.rank = scan.lru_rank;
          res_d.evicted = 1'b1;
        end
      end else if (item_q.op == lkvc_pkg::OpGet) begin
        if (scan.hit) begin
          res_d.value_out       = scan.hit_value;
          res_d.value_bytes_out = scan.hit_len;
          rank_cmd.op           = lkvc_pkg::RankTouch;
        end
      end else if (item_q.op == lkvc_pkg::OpUpdate) begin
        wr_en = scan.hit;
      end else if (item_q.op == lkvc_pkg::OpRemove) begin
        if (scan.hit) begin
          rank_cmd.op = lkvc_pkg::RankDrop;
        end
      end else if (item_q.op == lkvc_pkg::OpResetAll) begin
        rank_cmd.op = lkvc_pkg::RankClear;
      end else begin
        // unknown op: drop
      end
    end
  end

  always_comb begin
    out_data_o            = res_q;
    out_data_o.used_count = total;
    out_data_o.free_count = lkvc_pkg::CntW'(lkvc_pkg::Entries) - total;
  end

  lkvc_store u_store (
    .clk_i       (clk_i),
    .rd_addr_i   (scan_idx_q),
    .wr_en_i     (wr_en),
    .wr_key_en_i (wr_key_en),
    .wr_addr_i   (wr_addr),
    .wr_key_i    (item_q.key),
    .wr_value_i  (wr_value),
    .wr_len_i    (len_sat),
    .rd_key_o    (rd_key),
    .rd_value_o  (rd_value),
    .rd_len_o    (rd_len)
  );

  lkvc_rank u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (rank_cmd),
    .rd_idx_i   (cmp_idx_q),
    .rd_valid_o (rd_valid),
    .rd_rank_o  (rd_rank),
    .total_o    (total)
  );

  lkvc_match u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .cmp_en_i   (cmp_en_q),
    .cmp_idx_i  (cmp_idx_q),
    .key_i      (item_q.key),
    .rd_key_i   (rd_key),
    .rd_value_i (rd_value),
    .rd_len_i   (rd_len),
    .rd_valid_i (rd_valid),
    .rd_rank_i  (rd_rank),
    .scan_o     (scan)
  );

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= lkvc_pkg::CntW'(lkvc_pkg::Entries))
    else $error("fill count above entry count");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken again while an item is in flight");

  a_reject_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> !out_data_o.evicted)
    else $error("rejected item reports an eviction");

  a_update_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::StExec) |=> out_valid_o)
    else $error("update step not followed by a result");
`endif

endmodule

@@ src/lkvc_store.sv @@
// Key, value and length memories of the cache, one write and one read port.
// Depends on lkvc_pkg.
module lkvc_store (
  input  logic                       clk_i,
  input  logic [lkvc_pkg::IdxW-1:0]  rd_addr_i,
  input  logic                       wr_en_i,
  input  logic                       wr_key_en_i,
  input  logic [lkvc_pkg::IdxW-1:0]  wr_addr_i,
  input  logic [lkvc_pkg::KeyW-1:0]  wr_key_i,
  input  logic [lkvc_pkg::ValW-1:0]  wr_value_i,
  input  logic [lkvc_pkg::LenW-1:0]  wr_len_i,
  output logic [lkvc_pkg::KeyW-1:0]  rd_key_o,
  output logic [lkvc_pkg::ValW-1:0]  rd_value_o,
  output logic [lkvc_pkg::LenW-1:0]  rd_len_o
);

  logic [lkvc_pkg::KeyW-1:0] key_mem_q [lkvc_pkg::Entries];
  logic [lkvc_pkg::ValW-1:0] value_mem_q [lkvc_pkg::Entries];
  logic [lkvc_pkg::LenW-1:0] len_mem_q [lkvc_pkg::Entries];
  logic [lkvc_pkg::KeyW-1:0] rd_key_q;
  logic [lkvc_pkg::ValW-1:0] rd_value_q;
  logic [lkvc_pkg::LenW-1:0] rd_len_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      value_mem_q[wr_addr_i] <= wr_value_i;
      len_mem_q[wr_addr_i]   <= wr_len_i;
    end
    if (wr_key_en_i) begin
      key_mem_q[wr_addr_i] <= wr_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_q   <= key_mem_q[rd_addr_i];
    rd_value_q <= value_mem_q[rd_addr_i];
    rd_len_q   <= len_mem_q[rd_addr_i];
  end

  assign rd_key_o   = rd_key_q;
  assign rd_value_o = rd_value_q;
  assign rd_len_o   = rd_len_q;

endmodule

@@ src/lkvc_rank.sv @@
// Valid bits, recency ranks and fill count of the cache entries.
// Depends on lkvc_pkg; updated once per item by a rank command.
module lkvc_rank (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lkvc_pkg::rank_cmd_t        cmd_i,
  input  logic [lkvc_pkg::IdxW-1:0]  rd_idx_i,
  output logic                       rd_valid_o,
  output logic [lkvc_pkg::IdxW-1:0]  rd_rank_o,
  output logic [lkvc_pkg::CntW-1:0]  total_o
);

  logic [lkvc_pkg::Entries-1:0] valid_q, valid_d;
  logic [lkvc_pkg::IdxW-1:0]    rank_q [lkvc_pkg::Entries];
  logic [lkvc_pkg::IdxW-1:0]    rank_d [lkvc_pkg::Entries];
  logic [lkvc_pkg::CntW-1:0]    total_q, total_d;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    total_d = total_q;
    unique case (cmd_i.op)
      lkvc_pkg::RankNone: begin
      end
      lkvc_pkg::RankTouch: begin
        // move the entry to the front, shift the more recent ones back
        for (int i = 0; i < lkvc_pkg::Entries; i++) begin
          if (lkvc_pkg::IdxW'(i) == cmd_i.idx) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && rank_q[i] < cmd_i.rank) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
      end
      lkvc_pkg::RankPush: begin
        for (int i = 0; i < lkvc_pkg::Entries; i++) begin
          if (lkvc_pkg::IdxW'(i) == cmd_i.idx) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        total_d = total_q + 1'b1;
      end
      lkvc_pkg::RankDrop: begin
        for (int i = 0; i < lkvc_pkg::Entries; i++) begin
          if (lkvc_pkg::IdxW'(i) == cmd_i.idx) begin
            valid_d[i] = 1'b0;
            rank_d[i]  = '0;
          end else if (valid_q[i] && rank_q[i] > cmd_i.rank) begin
            rank_d[i] = rank_q[i] - 1'b1;
          end
        end
        total_d = total_q - 1'b1;
      end
      lkvc_pkg::RankClear: begin
        valid_d = '0;
        for (int i = 0; i < lkvc_pkg::Entries; i++) begin
          rank_d[i] = '0;
        end
        total_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      total_q <= '0;
      for (int i = 0; i < lkvc_pkg::Entries; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      total_q <= total_d;
      rank_q  <= rank_d;
    end
  end

  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];
  assign total_o    = total_q;

endmodule

@@ src/lkvc_match.sv @@
// Shared key comparator with hit, free-entry and LRU trackers.
// Sees one entry per cycle; depends on lkvc_pkg.
module lkvc_match (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       cmp_en_i,
  input  logic [lkvc_pkg::IdxW-1:0]  cmp_idx_i,
  input  logic [lkvc_pkg::KeyW-1:0]  key_i,
  input  logic [lkvc_pkg::KeyW-1:0]  rd_key_i,
  input  logic [lkvc_pkg::ValW-1:0]  rd_value_i,
  input  logic [lkvc_pkg::LenW-1:0]  rd_len_i,
  input  logic                       rd_valid_i,
  input  logic [lkvc_pkg::IdxW-1:0]  rd_rank_i,
  output lkvc_pkg::scan_t            scan_o
);

  lkvc_pkg::scan_t scan_q, scan_d;

  always_comb begin
    scan_d = scan_q;
    if (start_i) begin
      scan_d.hit        = 1'b0;
      scan_d.free_found = 1'b0;
    end else if (cmp_en_i) begin
      if (rd_valid_i && (rd_key_i == key_i) && !scan_q.hit) begin
        scan_d.hit       = 1'b1;
        scan_d.hit_idx   = cmp_idx_i;
        scan_d.hit_rank  = rd_rank_i;
        scan_d.hit_value = rd_value_i;
        scan_d.hit_len   = rd_len_i;
      end
      // lowest free entry wins
      if (!rd_valid_i && !scan_q.free_found) begin
        scan_d.free_found = 1'b1;
        scan_d.free_idx   = cmp_idx_i;
      end
      // first entry seeds the oldest, later ones replace it only when strictly older
      if (cmp_idx_i == '0 || rd_rank_i > scan_q.lru_rank) begin
        scan_d.lru_idx  = cmp_idx_i;
        scan_d.lru_rank = rd_rank_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule
